// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared constants and types for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [28:0] MAX_BYTES = 29'h1fffffff;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Classified command from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_FINISH,
    CMD_TOO_LONG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUNDS,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } back_state_t;

endpackage

// ===== sv/sha1_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher core
// Byte-stream SHA-1 with padding, digest output as five words.
// ----------------------------------------------------------------------------
// Items enter a short command queue, one per cycle while it has room; a final
// item that carries a byte takes two entries and holds the input off for one
// cycle. The engine takes one queued byte per cycle and, when a 64-byte block
// fills, runs 80 rounds during which the queue waits. At the end of a message
// the engine pads the block, runs its rounds and, when the length spills into a
// second block, runs that block too, then emits the digest words as the
// receiver takes them.
`include "assert_macros.svh"
module sha1_stream_hasher_core #(
  parameter int QueueDepth = sha1_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // msg_byte[7:0], has_byte[8], zero fill
  input  logic        s_axis_tlast,  // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], fill
  output logic        m_axis_tlast,  // last_word
  output logic        m_axis_tuser   // too_long
);
  import sha1_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic [31:0] word;
  logic [2:0]  idx;

  sha1_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata[7:0]), .in_has(s_axis_tdata[8]), .in_last(s_axis_tlast),
    .cmd_valid, .cmd_ready, .cmd
  );

  sha1_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(word), .out_index(idx), .out_lastw(m_axis_tlast),
    .out_toolong(m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, idx, word};

  `ASSERT_IMPL(a_toolong_single, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast && idx == 3'd0)
  `ASSERT_IMPL(a_index_range, clk, rst, m_axis_tvalid, idx <= 3'd4)
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(idx))

endmodule

// ===== sv/sha1_front.sv =====
// ----------------------------------------------------------------------------
// SHA-1 front end
// Accepts input items, counts bytes, flags over-long messages, queues
// commands for the compression engine.
// ----------------------------------------------------------------------------
module sha1_front #(
  parameter int Depth = sha1_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_has,
  input  logic          in_last,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output sha1_pkg::cmd_t cmd
);
  import sha1_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            q [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     fill;
  logic [28:0]     count;
  logic            ovf;
  logic            push, pop;
  logic            take, byte_ok, ovf_now;
  cmd_t            push_cmd;
  logic            pend_fin;

  // room for two entries, as a final item with a byte takes two
  assign in_ready  = !pend_fin && (fill < (AW+1)'(Depth - 1));
  assign take      = in_valid && in_ready;
  assign ovf_now   = ovf || (in_has && count == MAX_BYTES);
  assign byte_ok   = in_has && !ovf && count != MAX_BYTES;
  assign push      = take && (byte_ok || in_last);
  assign cmd_valid = fill != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_comb begin
    push_cmd.data = in_byte;
    if (!in_last) begin
      push_cmd.kind = CMD_BYTE;
    end else if (ovf_now) begin
      push_cmd.kind = CMD_TOO_LONG;
    end else begin
      push_cmd.kind = CMD_FINISH;
    end
  end

  // a final item with a byte queues the byte first, then FINISH in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; fill <= '0; count <= '0; ovf <= 1'b0;
      pend_fin <= 1'b0;
    end else begin
      if (push || pend_fin) begin
        wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (AW+1)'(push || pend_fin) - (AW+1)'(pop);
      pend_fin <= take && in_last && byte_ok;
      if (take) begin
        if (in_last) begin
          count <= '0; ovf <= 1'b0;
        end else begin
          ovf <= ovf_now;
          if (byte_ok) count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_fin) begin
      q[wr_ptr] <= '{kind: CMD_FINISH, data: 8'h00};
    end else if (push) begin
      q[wr_ptr] <= (in_last && byte_ok) ? '{kind: CMD_BYTE, data: in_byte} : push_cmd;
    end
  end

endmodule

// ===== sv/sha1_back.sv =====
// ----------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into the schedule ring, runs 80 rounds per block, pads and
// emits the digest words straight from the chain registers.
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sha1_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_word,
  output logic [2:0]     out_index,
  output logic           out_lastw,
  output logic           out_toolong
);
  import sha1_pkg::*;

  back_state_t state, state_next;
  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [5:0]  pos;
  logic [28:0] count;
  logic        final_blk;
  logic        pend_len;
  logic [2:0]  emit_idx;
  logic        emit_tl;

  logic [31:0] wt, f, k, tmp, wnew;
  logic [3:0]  ri;
  logic        accept_cmd, start_rounds, rounds_done;

  assign ri   = rnd[3:0];
  assign wnew = {w[ri+4'd13][30:0] ^ w[ri+4'd8][30:0] ^ w[ri+4'd2][30:0] ^ w[ri][30:0],
                 w[ri+4'd13][31] ^ w[ri+4'd8][31] ^ w[ri+4'd2][31] ^ w[ri][31]};
  assign wt   = (rnd < 7'd16) ? w[ri] : wnew;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) ^ (~b & d); k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) ^ (b & d) ^ (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + wt;
  end

  assign cmd_ready   = (state == ST_IDLE) && !out_valid;
  assign accept_cmd  = cmd_valid && cmd_ready;
  assign rounds_done = (state == ST_ROUNDS) && rnd == 7'd79;

  always_comb begin
    state_next = state;
    start_rounds = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept_cmd) begin
          case (cmd.kind)
            CMD_BYTE: if (pos == 6'd63) begin
              state_next = ST_ROUNDS; start_rounds = 1'b1;
            end
            CMD_FINISH: state_next = ST_PAD;
            CMD_TOO_LONG: state_next = ST_EMIT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PAD: begin
        state_next = ST_ROUNDS; start_rounds = 1'b1;
      end
      ST_ROUNDS: begin
        if (rnd == 7'd79) begin
          state_next = final_blk ? ST_EMIT : (pend_len ? ST_LEN : ST_IDLE);
        end
      end
      ST_LEN: begin
        state_next = ST_ROUNDS; start_rounds = 1'b1;
      end
      ST_EMIT: begin
        if (out_valid && out_ready && (out_lastw)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // chain update uses the working words after the last round
  logic [31:0] sum [5];
  always_comb begin
    sum[0] = h[0] + tmp; sum[1] = h[1] + a; sum[2] = h[2] + {b[1:0], b[31:2]};
    sum[3] = h[3] + c; sum[4] = h[4] + d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT; h[4] <= H4_INIT;
      pos <= '0; count <= '0; final_blk <= 1'b0; pend_len <= 1'b0;
      out_valid <= 1'b0; emit_idx <= '0; emit_tl <= 1'b0; rnd <= '0;
    end else begin
      state <= state_next;
      if (accept_cmd) begin
        case (cmd.kind)
          CMD_BYTE: begin
            pos <= pos + 1'b1; count <= count + 1'b1;
          end
          CMD_TOO_LONG: begin
            emit_tl <= 1'b1; emit_idx <= '0; out_valid <= 1'b1;
          end
          CMD_FINISH: begin
            pend_len <= (pos >= 6'd56);
            final_blk <= (pos < 6'd56);
          end
          default: ;
        endcase
      end
      if (start_rounds) begin
        rnd <= '0;
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        if (state == ST_LEN) begin
          final_blk <= 1'b1; pend_len <= 1'b0;
        end
      end else if (state == ST_ROUNDS) begin
        rnd <= rnd + 1'b1;
        e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
      end
      if (rounds_done) begin
        h[0] <= sum[0]; h[1] <= sum[1]; h[2] <= sum[2]; h[3] <= sum[3]; h[4] <= sum[4];
        if (final_blk) begin
          out_valid <= 1'b1; emit_idx <= '0; emit_tl <= 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (out_lastw) begin
          out_valid <= 1'b0; emit_tl <= 1'b0;
          h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT;
          h[4] <= H4_INIT;
          pos <= '0; count <= '0; final_blk <= 1'b0; pend_len <= 1'b0;
        end else begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end

  // schedule ring: byte packing, padding, length and schedule updates
  always_ff @(posedge clk) begin
    if (accept_cmd && cmd.kind == CMD_BYTE) begin
      case (pos[1:0])
        2'd0: w[pos[5:2]][31:24] <= cmd.data;
        2'd1: w[pos[5:2]][23:16] <= cmd.data;
        2'd2: w[pos[5:2]][15:8]  <= cmd.data;
        default: w[pos[5:2]][7:0] <= cmd.data;
      endcase
    end else if (state == ST_PAD) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(i*4+j) == pos) begin
            w[i][31-8*j -: 8] <= PAD_BYTE;
          end else if (6'(i*4+j) > pos) begin
            w[i][31-8*j -: 8] <= 8'h00;
          end
        end
      end
      if (pos < 6'd56) begin
        w[14] <= '0; w[15] <= {count, 3'b000};
      end
    end else if (state == ST_LEN) begin
      for (int i = 0; i < 14; i++) w[i] <= '0;
      w[14] <= '0; w[15] <= {count, 3'b000};
    end else if (state == ST_ROUNDS && rnd >= 7'd16) begin
      w[ri] <= wnew;
    end
  end

  assign out_word    = emit_tl ? 32'd0 : h[emit_idx];
  assign out_index   = emit_idx;
  assign out_lastw   = emit_tl || emit_idx == 3'd4;
  assign out_toolong = emit_tl;

endmodule
